### rtl/pngcs_pkg.sv
// Shared constants, codes and types for the PNG chunk scanner.
package pngcs_pkg;

    // Fixed field widths
    localparam int DATA_W     = 8;
    localparam int CFG_W      = 27;
    localparam int OFFSET_W   = 27;
    localparam int VERDICT_W  = 3;
    localparam int LEN_W      = 32;
    localparam int SKIP_W     = LEN_W + 1;
    localparam int SHIFT_W    = 64;
    localparam int SIZE_BITS_DEFAULT = 27;

    // Walk phases
    localparam logic [1:0] PH_SIG     = 2'd0;
    localparam logic [1:0] PH_HDR     = 2'd1;
    localparam logic [1:0] PH_SKIP    = 2'd2;
    localparam logic [1:0] PH_DISCARD = 2'd3;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] V_OK        = 3'd0;
    localparam logic [VERDICT_W-1:0] V_BAD_SIG   = 3'd1;
    localparam logic [VERDICT_W-1:0] V_TRUNC     = 3'd2;
    localparam logic [VERDICT_W-1:0] V_TOO_LONG  = 3'd3;
    localparam logic [VERDICT_W-1:0] V_ANIMATED  = 3'd4;
    localparam logic [VERDICT_W-1:0] V_NO_IMAGE  = 3'd5;

    // Signature, chunk types and header overhead
    localparam logic [SHIFT_W-1:0] PNG_SIGNATURE = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [LEN_W-1:0]   TYPE_ACTL     = 32'h6163_544C;
    localparam logic [LEN_W-1:0]   TYPE_IDAT     = 32'h4944_4154;
    localparam logic [LEN_W-1:0]   TYPE_IEND     = 32'h4945_4E44;
    localparam int                 CHUNK_OVERHEAD = 12;
    localparam int                 SIG_LEN        = 8;
    localparam int                 HDR_LEN        = 8;
    localparam int                 CRC_LEN        = 4;

    // One result beat from the walker
    typedef struct packed {
        logic                 valid;
        logic [VERDICT_W-1:0] verdict;
        logic [OFFSET_W-1:0]  offset;
    } result_t;

endpackage

### rtl/png_chunk_scanner_core.sv
// Top level of the PNG chunk scanner: state registers and result buffer.
//
// Streams the bytes of one file (s_tlast on the final byte), checks the PNG
// signature and walks the chunk headers, giving at most one verdict beat per
// file with the byte count at which it was reached. Throughput is one byte
// per clock while s_tready is high; each byte is handled in the cycle it is
// accepted, and each verdict is registered before it reaches the master
// side. The two-entry result buffer holds s_tready high until two verdicts
// wait. The user must write file_size via cfg_wr_en and cfg_wr_data only
// while no byte is in flight (unenforced); it survives the per-file rearm.
module png_chunk_scanner_core #(
    parameter int SIZE_BITS = pngcs_pkg::SIZE_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [pngcs_pkg::CFG_W-1:0]    cfg_wr_data,   // file_size
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,       // [7:0] data_byte
    input  logic                           s_tlast,       // end_of_file
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata        // [2:0] verdict,
                                                          // [29:3] verdict_offset
);
    import pngcs_pkg::*;

    localparam int FS_W = (SIZE_BITS < CFG_W) ? SIZE_BITS : CFG_W;

    logic [FS_W-1:0]      file_size_reg;
    logic [1:0]           phase_reg, phase_next;
    logic [SIZE_BITS-1:0] byte_offset_reg, byte_offset_next;
    logic [SIZE_BITS-1:0] chunk_start_reg, chunk_start_next;
    logic [SHIFT_W-1:0]   header_shift_reg, header_shift_next;
    logic [SKIP_W-1:0]    skip_remaining_reg, skip_remaining_next;
    result_t              walk_result;
    logic                 in_beat;
    logic                 new_result;
    logic                 drain;

    logic                 main_valid_reg;
    logic [VERDICT_W-1:0] main_verdict_reg;
    logic [OFFSET_W-1:0]  main_offset_reg;
    logic                 skid_valid_reg;
    logic [VERDICT_W-1:0] skid_verdict_reg;
    logic [OFFSET_W-1:0]  skid_offset_reg;

    assign in_beat    = s_tvalid && s_tready;
    assign new_result = in_beat && walk_result.valid;
    assign drain      = main_valid_reg && m_tready;
    assign s_tready   = !skid_valid_reg;

    // Walk logic for the current beat
    pngcs_walk #(
        .SIZE_BITS(SIZE_BITS)
    ) u_walk (
        .data_byte          (s_tdata),
        .end_of_file        (s_tlast),
        .file_size          (SIZE_BITS'(file_size_reg)),
        .phase              (phase_reg),
        .byte_offset        (byte_offset_reg),
        .chunk_start        (chunk_start_reg),
        .header_shift       (header_shift_reg),
        .skip_remaining     (skip_remaining_reg),
        .phase_next         (phase_next),
        .byte_offset_next   (byte_offset_next),
        .chunk_start_next   (chunk_start_next),
        .header_shift_next  (header_shift_next),
        .skip_remaining_next(skip_remaining_next),
        .result             (walk_result)
    );

    // Hold the configured file size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_size_reg <= '0;
        end else if (cfg_wr_en) begin
            file_size_reg <= cfg_wr_data[FS_W-1:0];
        end
    end

    // Advance the walk state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_SIG;
            byte_offset_reg    <= '0;
            chunk_start_reg    <= SIZE_BITS'(SIG_LEN);
            header_shift_reg   <= '0;
            skip_remaining_reg <= '0;
        end else if (in_beat) begin
            phase_reg          <= phase_next;
            byte_offset_reg    <= byte_offset_next;
            chunk_start_reg    <= chunk_start_next;
            header_shift_reg   <= header_shift_next;
            skip_remaining_reg <= skip_remaining_next;
        end
    end

    // Result buffer: main register with a skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (drain) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (new_result) begin
            if (!main_valid_reg || drain) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (drain) begin
            main_valid_reg <= 1'b0;
        end
    end

    // Move payloads through the buffer
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (drain) begin
                main_verdict_reg <= skid_verdict_reg;
                main_offset_reg  <= skid_offset_reg;
            end
        end else if (new_result) begin
            if (!main_valid_reg || drain) begin
                main_verdict_reg <= walk_result.verdict;
                main_offset_reg  <= walk_result.offset;
            end else begin
                skid_verdict_reg <= walk_result.verdict;
                skid_offset_reg  <= walk_result.offset;
            end
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {2'b00, main_offset_reg, main_verdict_reg};

endmodule

### rtl/pngcs_walk.sv
// Next-state and verdict logic for one byte of the chunk walk.
module pngcs_walk #(
    parameter int SIZE_BITS = pngcs_pkg::SIZE_BITS_DEFAULT
) (
    input  logic [pngcs_pkg::DATA_W-1:0]  data_byte,
    input  logic                          end_of_file,
    input  logic [SIZE_BITS-1:0]          file_size,
    input  logic [1:0]                    phase,
    input  logic [SIZE_BITS-1:0]          byte_offset,
    input  logic [SIZE_BITS-1:0]          chunk_start,
    input  logic [pngcs_pkg::SHIFT_W-1:0] header_shift,
    input  logic [pngcs_pkg::SKIP_W-1:0]  skip_remaining,
    output logic [1:0]                    phase_next,
    output logic [SIZE_BITS-1:0]          byte_offset_next,
    output logic [SIZE_BITS-1:0]          chunk_start_next,
    output logic [pngcs_pkg::SHIFT_W-1:0] header_shift_next,
    output logic [pngcs_pkg::SKIP_W-1:0]  skip_remaining_next,
    output pngcs_pkg::result_t            result
);
    import pngcs_pkg::*;

    localparam int SUMW = ((SIZE_BITS > SKIP_W) ? SIZE_BITS : SKIP_W) + 1;
    localparam int CMPW = SIZE_BITS + 1;

    logic [SIZE_BITS-1:0] boff_inc;
    logic [SHIFT_W-1:0]   hs_in;
    logic [LEN_W-1:0]     chunk_len;
    logic [LEN_W-1:0]     chunk_type;
    logic                 room_ok;
    logic [SIZE_BITS-1:0] room;
    logic                 too_long;
    logic [SKIP_W-1:0]    skip_dec;
    logic [SUMW-1:0]      next_chunk_sum;
    logic [SUMW-1:0]      early_end_sum;
    logic                 do_reach;
    logic [SIZE_BITS-1:0] reach_start;
    logic                 do_emit;
    logic [VERDICT_W-1:0] verdict;

    // Shared datapath terms
    always_comb begin
        boff_inc   = byte_offset + SIZE_BITS'(1);
        hs_in      = {header_shift[SHIFT_W-DATA_W-1:0], data_byte};
        chunk_len  = hs_in[SHIFT_W-1:LEN_W];
        chunk_type = hs_in[LEN_W-1:0];
        room_ok    = {1'b0, file_size} >=
                     ({1'b0, chunk_start} + CMPW'(CHUNK_OVERHEAD));
        room       = room_ok ? (file_size - chunk_start - SIZE_BITS'(CHUNK_OVERHEAD))
                             : '0;
        too_long   = SUMW'(chunk_len) > SUMW'(room);
        skip_dec   = (skip_remaining != '0) ? (skip_remaining - SKIP_W'(1)) : '0;
        next_chunk_sum = SUMW'(chunk_start) + SUMW'(chunk_len) + SUMW'(CHUNK_OVERHEAD);
        early_end_sum  = SUMW'(boff_inc) + SUMW'(skip_dec);
    end

    // Walk one byte
    always_comb begin
        phase_next          = phase;
        byte_offset_next    = byte_offset;
        chunk_start_next    = chunk_start;
        header_shift_next   = header_shift;
        skip_remaining_next = skip_remaining;
        do_reach            = 1'b0;
        reach_start         = chunk_start;
        do_emit             = 1'b0;
        verdict             = V_OK;

        unique case (phase)
            PH_SIG: begin
                byte_offset_next  = boff_inc;
                header_shift_next = hs_in;
                if (boff_inc >= SIZE_BITS'(SIG_LEN)) begin
                    if (hs_in != PNG_SIGNATURE) begin
                        do_emit = 1'b1;
                        verdict = V_BAD_SIG;
                    end else begin
                        do_reach    = 1'b1;
                        reach_start = SIZE_BITS'(SIG_LEN);
                    end
                end else if (end_of_file) begin
                    do_emit = 1'b1;
                    verdict = V_BAD_SIG;
                end
            end
            PH_HDR: begin
                byte_offset_next  = boff_inc;
                header_shift_next = hs_in;
                if ((boff_inc - chunk_start) >= SIZE_BITS'(HDR_LEN)) begin
                    if (too_long) begin
                        do_emit = 1'b1;
                        verdict = V_TOO_LONG;
                    end else if (chunk_type == TYPE_ACTL) begin
                        do_emit = 1'b1;
                        verdict = V_ANIMATED;
                    end else if (chunk_type == TYPE_IDAT || chunk_type == TYPE_IEND) begin
                        do_emit = 1'b1;
                        verdict = V_OK;
                    end else begin
                        skip_remaining_next = SKIP_W'(chunk_len) + SKIP_W'(CRC_LEN);
                        if (end_of_file) begin
                            do_reach    = 1'b1;
                            reach_start = next_chunk_sum[SIZE_BITS-1:0];
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                end else if (end_of_file) begin
                    do_emit = 1'b1;
                    verdict = V_TRUNC;
                end
            end
            PH_SKIP: begin
                byte_offset_next    = boff_inc;
                skip_remaining_next = skip_dec;
                if (skip_dec == '0) begin
                    do_reach    = 1'b1;
                    reach_start = boff_inc;
                end else if (end_of_file) begin
                    do_reach    = 1'b1;
                    reach_start = early_end_sum[SIZE_BITS-1:0];
                end
            end
            PH_DISCARD: begin
                // Drop bytes until the end mark
            end
            default: begin
            end
        endcase

        // Arrive at a chunk start: test the room left
        if (do_reach) begin
            chunk_start_next  = reach_start;
            header_shift_next = '0;
            if ({1'b0, file_size} < ({1'b0, reach_start} + CMPW'(CHUNK_OVERHEAD))) begin
                do_emit = 1'b1;
                verdict = V_NO_IMAGE;
            end else if (end_of_file) begin
                do_emit = 1'b1;
                verdict = V_TRUNC;
            end else begin
                phase_next = PH_HDR;
            end
        end

        // After a verdict hold off until the end mark
        if (do_emit) begin
            phase_next = PH_DISCARD;
        end

        // Rearm on the end mark after a verdict or in discard
        if ((do_emit || phase == PH_DISCARD) && end_of_file) begin
            phase_next          = PH_SIG;
            byte_offset_next    = '0;
            chunk_start_next    = SIZE_BITS'(SIG_LEN);
            header_shift_next   = '0;
            skip_remaining_next = '0;
        end

        result.valid   = do_emit;
        result.verdict = verdict;
        result.offset  = OFFSET_W'(byte_offset_next);
        if (do_emit) begin
            result.offset = OFFSET_W'(boff_inc);
        end
    end

endmodule
